### rtl/core/oled_text_glyph_streamer_unit_defines.svh
// ---------------------------------------------------------------------------
// oled_text_glyph_streamer_unit_defines.svh
// Assertion macros used by the glyph streamer serializer.
// ---------------------------------------------------------------------------
`ifndef OLED_TEXT_GLYPH_STREAMER_UNIT_DEFINES_SVH
`define OLED_TEXT_GLYPH_STREAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define OTGS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define OTGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/oled_tgs_pkg.sv
// ---------------------------------------------------------------------------
// oled_tgs_pkg
// Types, constants and the 6x8 font ROM for the OLED text glyph streamer.
// ---------------------------------------------------------------------------
`default_nettype none

package oled_tgs_pkg;

	// glyph columns sent per character (1..8)
	localparam int GLYPH_COLUMNS = 6;

	// bytes per character: three page-mode commands, then the glyph columns
	localparam int BEATS  = 3 + GLYPH_COLUMNS;
	localparam int BEAT_W = $clog2(BEATS);

	typedef logic [BEAT_W-1:0] beat_t;

	localparam beat_t BEAT_PAGE   = BEAT_W'(0);
	localparam beat_t BEAT_COL_HI = BEAT_W'(1);
	localparam beat_t BEAT_COL_LO = BEAT_W'(2);
	localparam beat_t BEAT_GLYPH  = BEAT_W'(3);
	localparam beat_t BEAT_LAST   = BEAT_W'(BEATS - 1);

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HI    = 8'h10;

	localparam logic [7:0] WRAP_LIMIT = 8'd126;

	localparam logic [7:0] FONT_FIRST = 8'd32;
	localparam logic [7:0] FONT_LAST  = 8'd123;
	localparam int         FONT_WIDTH = 6;
	localparam int         FONT_ROW_W = 8 * FONT_WIDTH;
	localparam int         FONT_CHARS = 92;

	typedef struct packed {
		logic [7:0] code;
		logic [6:0] column;
		logic [2:0] page;
	} glyph_item_t;

	// one row per character, first column in the top byte
	localparam logic [FONT_ROW_W-1:0] FONT_ROM [FONT_CHARS] = '{
		48'h000000000000, 48'h0000002f0000, 48'h000007000700, 48'h00147f147f14,
		48'h00242a7f2a12, 48'h006264081323, 48'h003649552250, 48'h000005030000,
		48'h00001c224100, 48'h000041221c00, 48'h0014083E0814, 48'h0008083E0808,
		48'h000000A06000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
		48'h003E5149453E, 48'h0000427F4000, 48'h004261514946, 48'h002141454B31,
		48'h001814127F10, 48'h002745454539, 48'h003C4A494930, 48'h000171090503,
		48'h003649494936, 48'h00064949291E, 48'h000036360000, 48'h000056360000,
		48'h000814224100, 48'h001414141414, 48'h000041221408, 48'h000201510906,
		48'h00324959513E, 48'h007C1211127C, 48'h007F49494936, 48'h003E41414122,
		48'h007F4141221C, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
		48'h007F0808087F, 48'h0000417F4100, 48'h002040413F01, 48'h007F08142241,
		48'h007F40404040, 48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E,
		48'h007F09090906, 48'h003E4151215E, 48'h007F09192946, 48'h004649494931,
		48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F,
		48'h006314081463, 48'h000708700807, 48'h006151494543, 48'h00007F414100,
		48'h00552A552A55, 48'h000041417F00, 48'h000402010204, 48'h004040404040,
		48'h000001020400, 48'h002054545478, 48'h007F48444438, 48'h003844444420,
		48'h00384444487F, 48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C,
		48'h007F08040478, 48'h0000447D4000, 48'h004080847D00, 48'h007F10284400,
		48'h0000417F4000, 48'h007C04180478, 48'h007C08040478, 48'h003844444438,
		48'h00FC24242418, 48'h0018242418FC, 48'h007C08040408, 48'h004854545420,
		48'h00043F444020, 48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C,
		48'h004428102844, 48'h001CA0A0A07C, 48'h004464544C44, 48'h141414141414
	};

	// glyph column byte for a glyph beat; blank for codes without a glyph
	// and for columns beyond the font width
	function automatic logic [7:0] glyph_byte(input logic [7:0] code, input beat_t beat);
		beat_t      gcol;
		logic [6:0] idx;
		logic [2:0] fc;
		logic [7:0] res;
		gcol = beat - BEAT_GLYPH;
		idx  = 7'(code - FONT_FIRST);
		fc   = 3'(gcol);
		res  = 8'h00;
		if (code >= FONT_FIRST && code <= FONT_LAST && 32'(gcol) < FONT_WIDTH) begin
			res = 8'(FONT_ROM[idx] >> (6'(FONT_ROW_W - 8) - {fc, 3'b000}));
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### rtl/core/oled_tgs_cursor.sv
// ---------------------------------------------------------------------------
// oled_tgs_cursor
// Text cursor: optional load, line wrap, and advance by one glyph width.
// ---------------------------------------------------------------------------
`default_nettype none

module oled_tgs_cursor (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [7:0]                char_code,
	input  wire logic                      load_position,
	input  wire logic [6:0]                start_column,
	input  wire logic [2:0]                start_page,
	output oled_tgs_pkg::glyph_item_t      item
);

	logic [7:0] cursor_column_q;
	logic [2:0] cursor_page_q;

	logic [7:0] base_column;
	logic [2:0] base_page;
	logic       wrap;
	logic [6:0] draw_column;
	logic [2:0] draw_page;

	always_comb begin
		base_column = load_position ? {1'b0, start_column} : cursor_column_q;
		base_page   = load_position ? start_page : cursor_page_q;
		wrap        = base_column > oled_tgs_pkg::WRAP_LIMIT;
		// after wrap the column is at most 126, so seven bits hold it
		draw_column = wrap ? 7'd0 : base_column[6:0];
		draw_page   = base_page + 3'(wrap);
	end

	assign item = '{code: char_code, column: draw_column, page: draw_page};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= 8'd0;
			cursor_page_q   <= 3'd0;
		end else if (accept) begin
			cursor_column_q <= {1'b0, draw_column} + 8'(oled_tgs_pkg::GLYPH_COLUMNS);
			cursor_page_q   <= draw_page;
		end
	end

endmodule

`default_nettype wire

### rtl/core/oled_tgs_serializer.sv
// ---------------------------------------------------------------------------
// oled_tgs_serializer
// Holds one character and streams its command and glyph bytes through an
// output register, one byte per cycle while out_stall is low.
// ---------------------------------------------------------------------------
`default_nettype none

`include "oled_text_glyph_streamer_unit_defines.svh"

module oled_tgs_serializer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	input  wire oled_tgs_pkg::glyph_item_t item,
	output logic                           item_stall,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     out_byte,
	output logic                           is_data,
	output logic                           last
);

	logic                      valid_s1;
	oled_tgs_pkg::glyph_item_t item_s1;
	oled_tgs_pkg::beat_t       beat_q;

	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      is_data_q;
	logic                      last_q;

	logic                      out_load;
	logic                      emit;
	logic                      final_beat;
	logic                      item_take;
	logic [7:0]                next_byte;
	logic                      next_data;

	always_comb begin
		out_load   = !out_valid_q || !out_stall;
		emit       = out_load && valid_s1;
		final_beat = beat_q == oled_tgs_pkg::BEAT_LAST;
		item_stall = valid_s1 && !(emit && final_beat);
		item_take  = item_valid && !item_stall;
	end

	always_comb begin
		next_data = 1'b0;
		case (beat_q)
			oled_tgs_pkg::BEAT_PAGE: begin
				next_byte = oled_tgs_pkg::CMD_PAGE_BASE | {5'd0, item_s1.page};
			end
			oled_tgs_pkg::BEAT_COL_HI: begin
				next_byte = oled_tgs_pkg::CMD_COL_HI | {5'd0, item_s1.column[6:4]};
			end
			oled_tgs_pkg::BEAT_COL_LO: begin
				next_byte = {4'd0, item_s1.column[3:0]};
			end
			default: begin
				next_byte = oled_tgs_pkg::glyph_byte(item_s1.code, beat_q);
				next_data = 1'b1;
			end
		endcase
	end

	// character holding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= oled_tgs_pkg::BEAT_PAGE;
		end else begin
			if (item_take) begin
				valid_s1 <= 1'b1;
			end else if (emit && final_beat) begin
				valid_s1 <= 1'b0;
			end
			if (emit) begin
				beat_q <= final_beat ? oled_tgs_pkg::BEAT_PAGE : beat_q + oled_tgs_pkg::beat_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			is_data_q  <= next_data;
			last_q     <= final_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign is_data   = is_data_q;
	assign last      = last_q;

	`OTGS_ASSERT_NOW(a_idle_beat_zero, !valid_s1, beat_q == oled_tgs_pkg::BEAT_PAGE,
		"beat counter left nonzero with no character held")
	`OTGS_ASSERT_NOW(a_last_is_data, out_valid_q && last_q, is_data_q,
		"final byte of a character is not a data byte")
	`OTGS_ASSERT_NEXT(a_take_starts, item_take,
		valid_s1 && beat_q == oled_tgs_pkg::BEAT_PAGE,
		"accepted character does not start at the page command")
	`OTGS_ASSERT_NEXT(a_final_wraps, emit && final_beat, beat_q == oled_tgs_pkg::BEAT_PAGE,
		"beat counter did not return after the final byte")

endmodule

`default_nettype wire

### rtl/core/oled_text_glyph_streamer_unit.sv
// ---------------------------------------------------------------------------
// oled_text_glyph_streamer_unit
// 6x8 text renderer producing page-mode commands and glyph bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one character per item with
//   an optional cursor load (load_position, start_column, start_page).
//   Output channel (out_valid / out_stall) gives nine bytes per character:
//   page command, high column command, low column command (is_data = 0),
//   then six glyph column bytes (is_data = 1), last set on the ninth.
//   A taken character is registered in the holding stage; its bytes then
//   pass through the output register, one byte per cycle while the output
//   is not stalled. The next character is taken in the cycle the ninth
//   byte of the current one enters the register.
//   A stall on the output holds the presented byte; the held character
//   waits and in_stall stays high until its last byte enters the register.
//   Reset clears the cursor to column 0, page 0 and empties both stages.
// ---------------------------------------------------------------------------
`default_nettype none

module oled_text_glyph_streamer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       load_position,
	input  wire logic [6:0] start_column,
	input  wire logic [2:0] start_page,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            is_data,
	output logic            last
);

	oled_tgs_pkg::glyph_item_t item;
	logic                      accept;

	assign accept = in_valid && !in_stall;

	oled_tgs_cursor u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.char_code     (char_code),
		.load_position (load_position),
		.start_column  (start_column),
		.start_page    (start_page),
		.item          (item)
	);

	oled_tgs_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid),
		.item       (item),
		.item_stall (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_data    (is_data),
		.last       (last)
	);

endmodule

`default_nettype wire
